/* rtl/qtd_pkg.sv */
// ----------------------------------------------------------------------------
// Q-table TD update: shared package
// Types, register indexes, sequencer states and fixed-point constants.
// ----------------------------------------------------------------------------
package qtd_pkg;

  localparam int NUM_STATES_DEF  = 16;
  localparam int NUM_ACTIONS_DEF = 4;

  // Fixed widths of the request and result fields.
  localparam int STATE_W  = 4;
  localparam int ACTION_W = 2;
  localparam int REWARD_W = 16;
  localparam int VALUE_W  = 32;
  localparam int BEST_W   = 2;
  localparam int OUTC_W   = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0]  REG_DISCOUNT      = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_LEARNING_RATE = 1'd1;
  localparam logic [CFG_DATA_W-1:0] COEF_RESET        = 9'd77;
  localparam logic [CFG_DATA_W-1:0] COEF_MAX          = 9'd256;

  // Arithmetic widths.
  localparam int PROD1_W = VALUE_W + CFG_DATA_W + 1;  // discount * max
  localparam int ERR_W   = 36;                        // target - old value
  localparam int PROD2_W = ERR_W + CFG_DATA_W + 1;    // rate * error
  localparam int NV_W    = VALUE_W + 5;               // unsaturated new value
  localparam int FRAC_W  = 8;

  localparam logic signed [VALUE_W-1:0]  Q_MAX       = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0]  Q_MIN       = 32'sh8000_0000;
  localparam logic signed [REWARD_W-1:0] WIN_REWARD  = 16'sd100;
  localparam logic signed [REWARD_W-1:0] LOSS_REWARD = -16'sd100;

  typedef enum logic [OUTC_W-1:0] {
    OUT_CONTINUE = 2'd0,
    OUT_WIN      = 2'd1,
    OUT_LOSS     = 2'd2
  } outcome_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_MUL1,
    ST_ERR,
    ST_MUL2,
    ST_WRITE
  } state_e;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic cmp_en;     // a row value is on the read data
    logic cmp_first;  // it is the row's first column
    logic ld_prod1;   // capture old value and discounted maximum
    logic ld_err;     // form the temporal-difference error
    logic ld_prod2;   // scale the error by the learning rate
  } dp_ctrl_t;

endpackage

/* rtl/qtd_mem.sv */
// ----------------------------------------------------------------------------
// Q-table TD update: value memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module qtd_mem #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/qtd_datapath.sv */
// ----------------------------------------------------------------------------
// Q-table TD update: datapath
// Row maximum search, the two scaled products and the saturating update.
// ----------------------------------------------------------------------------
module qtd_datapath #(
  parameter int COL_W = 2
) (
  input  logic                                  clk_i,
  input  qtd_pkg::dp_ctrl_t                     ctrl_i,
  input  logic [COL_W-1:0]                      col_i,
  input  logic [qtd_pkg::VALUE_W-1:0]           rdata_i,
  input  logic signed [qtd_pkg::REWARD_W-1:0]   reward_i,
  input  logic [qtd_pkg::CFG_DATA_W-1:0]        discount_i,
  input  logic [qtd_pkg::CFG_DATA_W-1:0]        rate_i,
  output logic [COL_W-1:0]                      best_o,
  output logic [qtd_pkg::VALUE_W-1:0]           new_value_o,
  output logic                                  sat_o
);
  import qtd_pkg::*;

  logic signed [VALUE_W-1:0] rd_val;
  logic signed [VALUE_W-1:0] max_q;
  logic [COL_W-1:0]          best_q;
  logic signed [VALUE_W-1:0] old_q;
  logic signed [PROD1_W-1:0] prod1_q;
  logic signed [ERR_W-1:0]   err_q;
  logic signed [PROD2_W-1:0] prod2_q;
  logic signed [NV_W-1:0]    nv_wide;

  assign rd_val = $signed(rdata_i);

  // A strictly greater value replaces the maximum, so ties keep the lower column.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp_en && (ctrl_i.cmp_first || rd_val > max_q)) begin
      max_q  <= rd_val;
      best_q <= col_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_prod1) begin
      old_q   <= rd_val;
      prod1_q <= PROD1_W'($signed({1'b0, discount_i})) * PROD1_W'(max_q);
    end
    if (ctrl_i.ld_err) begin
      err_q <= (ERR_W'(reward_i) <<< FRAC_W) + ERR_W'(prod1_q >>> FRAC_W)
               - ERR_W'(old_q);
    end
    if (ctrl_i.ld_prod2) begin
      prod2_q <= PROD2_W'($signed({1'b0, rate_i})) * PROD2_W'(err_q);
    end
  end

  // The arithmetic shifts give the floor of each product over 256.
  assign nv_wide = NV_W'(old_q) + NV_W'(prod2_q >>> FRAC_W);

  always_comb begin
    if (nv_wide > NV_W'(Q_MAX)) begin
      new_value_o = Q_MAX;
      sat_o       = 1'b1;
    end else if (nv_wide < NV_W'(Q_MIN)) begin
      new_value_o = Q_MIN;
      sat_o       = 1'b1;
    end else begin
      new_value_o = nv_wide[VALUE_W-1:0];
      sat_o       = 1'b0;
    end
  end

  assign best_o = best_q;

endmodule

/* rtl/q_table_td_update_top.sv */
// ----------------------------------------------------------------------------
// Q-table TD update: top level
// Sequencer, configuration registers, value memory and result register.
// ----------------------------------------------------------------------------
// After reset the block first clears the value table, one entry a cycle; no
// request is taken during that sweep, though configuration writes are. After
// acceptance of a request, the single read port of the value memory reads the
// next state's row one column per cycle, then the current entry, and the update
// passes through two registered multiplications before it is written back and
// shown at the result port. Requests are handled one at a time, so no two
// accesses to the same entry overlap. A result waiting at the output does not
// stop the next request from being accepted; only the write-back waits.
// ----------------------------------------------------------------------------
module q_table_td_update_top #(
  parameter int NUM_STATES  = qtd_pkg::NUM_STATES_DEF,
  parameter int NUM_ACTIONS = qtd_pkg::NUM_ACTIONS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [qtd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [qtd_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [qtd_pkg::STATE_W-1:0]          state_index_i,
  input  logic [qtd_pkg::ACTION_W-1:0]         action_i,
  input  logic signed [qtd_pkg::REWARD_W-1:0]  reward_i,
  input  logic [qtd_pkg::STATE_W-1:0]          next_index_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [qtd_pkg::VALUE_W-1:0]   new_value_o,
  output logic [qtd_pkg::BEST_W-1:0]           best_next_action_o,
  output logic [qtd_pkg::OUTC_W-1:0]           outcome_o,
  output logic                                 saturated_o
);
  import qtd_pkg::*;

  localparam int DEPTH  = NUM_STATES * NUM_ACTIONS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(NUM_STATES);
  localparam int COL_W  = $clog2(NUM_ACTIONS);

  state_e state_q, state_d;

  logic [CFG_DATA_W-1:0] discount_q, rate_q, cfg_clamped;

  logic [ROW_W-1:0] s_row_in, n_row_in, s_row_q, n_row_q;
  logic [COL_W-1:0] a_col_in, a_col_q;
  logic signed [REWARD_W-1:0] reward_q;

  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [COL_W-1:0]  cmp_col_q;

  logic [ADDR_W-1:0] scan_addr, sa_addr;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [VALUE_W-1:0] mem_wdata, mem_rdata;

  dp_ctrl_t           dp_ctrl;
  logic [COL_W-1:0]   dp_best;
  logic [VALUE_W-1:0] dp_value;
  logic               dp_sat;

  logic in_acc, out_load, out_free;
  logic out_valid_q;
  logic [VALUE_W-1:0] out_value_q;
  logic [BEST_W-1:0]  out_best_q;
  outcome_e           out_outc_q, outc;
  logic               out_sat_q;

  // Configuration registers: values above 256 act as 256.
  assign cfg_ready_o = 1'b1;
  assign cfg_clamped = (cfg_data_i > COEF_MAX) ? COEF_MAX : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      discount_q <= COEF_RESET;
      rate_q     <= COEF_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DISCOUNT:      discount_q <= cfg_clamped;
        REG_LEARNING_RATE: rate_q     <= cfg_clamped;
        default: ;
      endcase
    end
  end

  // Out-of-range indexes act as the last row or column.
  assign s_row_in = (32'(state_index_i) >= 32'(NUM_STATES)) ?
                    ROW_W'(NUM_STATES - 1) : ROW_W'(state_index_i);
  assign n_row_in = (32'(next_index_i) >= 32'(NUM_STATES)) ?
                    ROW_W'(NUM_STATES - 1) : ROW_W'(next_index_i);
  assign a_col_in = (32'(action_i) >= 32'(NUM_ACTIONS)) ?
                    COL_W'(NUM_ACTIONS - 1) : COL_W'(action_i);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s_row_q  <= s_row_in;
      n_row_q  <= n_row_in;
      a_col_q  <= a_col_in;
      reward_q <= reward_i;
    end
  end

  assign scan_addr = ADDR_W'(n_row_q) * ADDR_W'(NUM_ACTIONS) + ADDR_W'(col_q);
  assign sa_addr   = ADDR_W'(s_row_q) * ADDR_W'(NUM_ACTIONS) + ADDR_W'(a_col_q);

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      col_q     <= '0;
      clr_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      clr_q     <= clr_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_col_q <= col_q;
  end

  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    clr_d     = clr_q;
    cmp_vld_d = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = sa_addr;
    mem_raddr = sa_addr;
    mem_wdata = dp_value;
    out_load  = 1'b0;
    dp_ctrl   = '0;
    dp_ctrl.cmp_en    = cmp_vld_q;
    dp_ctrl.cmp_first = (cmp_col_q == '0);
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        col_d = '0;
        if (in_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = scan_addr;
        cmp_vld_d = 1'b1;
        col_d     = col_q + 1'b1;
        if (col_q == COL_W'(NUM_ACTIONS - 1)) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        mem_re  = 1'b1;
        state_d = ST_MUL1;
      end
      ST_MUL1: begin
        dp_ctrl.ld_prod1 = 1'b1;
        state_d          = ST_ERR;
      end
      ST_ERR: begin
        dp_ctrl.ld_err = 1'b1;
        state_d        = ST_MUL2;
      end
      ST_MUL2: begin
        dp_ctrl.ld_prod2 = 1'b1;
        state_d          = ST_WRITE;
      end
      ST_WRITE: begin
        // The write-back and the result go together once the output is free.
        if (out_free) begin
          mem_we   = 1'b1;
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  qtd_mem #(
    .DEPTH  (DEPTH),
    .DATA_W (VALUE_W),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  qtd_datapath #(
    .COL_W (COL_W)
  ) u_datapath (
    .clk_i       (clk_i),
    .ctrl_i      (dp_ctrl),
    .col_i       (cmp_col_q),
    .rdata_i     (mem_rdata),
    .reward_i    (reward_q),
    .discount_i  (discount_q),
    .rate_i      (rate_q),
    .best_o      (dp_best),
    .new_value_o (dp_value),
    .sat_o       (dp_sat)
  );

  always_comb begin
    if (reward_q == WIN_REWARD) begin
      outc = OUT_WIN;
    end else if (reward_q == LOSS_REWARD) begin
      outc = OUT_LOSS;
    end else begin
      outc = OUT_CONTINUE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= dp_value;
      out_best_q  <= BEST_W'(dp_best);
      out_outc_q  <= outc;
      out_sat_q   <= dp_sat;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign new_value_o        = $signed(out_value_q);
  assign best_next_action_o = out_best_q;
  assign outcome_o          = out_outc_q;
  assign saturated_o        = out_sat_q;

endmodule
